// ===== rtl/rocket_flight_physics_step_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rocket flight physics step unit assertion macros
// Shared immediate-consequence and next-cycle assertion forms.
// ----------------------------------------------------------------------------
`ifndef ROCKET_FLIGHT_PHYSICS_STEP_UNIT_MACROS_SVH
`define ROCKET_FLIGHT_PHYSICS_STEP_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfps_pkg.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics step package
// Widths, constants, step sequence, command types and arithmetic helpers.
// ----------------------------------------------------------------------------
package rfps_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W  = 40;
  localparam int VEL_W  = 32;
  localparam int TIME_W = 48;
  localparam int TICK_W = 20;
  localparam int MASS_W = 32;
  localparam int AREA_W = 32;
  localparam int THR_W  = 36;
  localparam int CFG_W  = 40;
  localparam int IDX_W  = 3;

  localparam int MAG_W  = VEL_W + 1;
  localparam int OPND_W = 64;
  localparam int PROD_W = 2 * OPND_W;
  localparam int CAP_W  = 63;
  localparam int QBITS  = 33;
  localparam int DVS_W  = 32;
  localparam int DVD_W  = 80;
  localparam int EXT_W  = 36;
  localparam int TMP_W  = 52;

  localparam logic [CAP_W-1:0] CAP_Q = {1'b1, {(CAP_W-1){1'b0}}};

  localparam longint GRAV_L = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint SINK_L = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [EXT_W-1:0] GRAV_Q = EXT_W'(GRAV_L);
  localparam logic [VEL_W-1:0] NEG_SINK_Q = VEL_W'(-SINK_L);
  // Division by one million of a product below 2^52 is exact as a multiply
  // by ceil(2^72 / 10^6) followed by a right shift of 72.
  localparam int US_SHIFT = 72;
  localparam logic [OPND_W-1:0] US_RECIP = 64'd4722366482869646;
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000);

  localparam logic [IDX_W-1:0] REG_GROUND = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIND_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIND_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIND_Z = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRAG   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TICK   = 3'd5;

  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_SQ   = 4'd0;
  localparam logic [PH_W-1:0] PH_SQRT = 4'd1;
  localparam logic [PH_W-1:0] PH_K    = 4'd2;
  localparam logic [PH_W-1:0] PH_KM   = 4'd3;
  localparam logic [PH_W-1:0] PH_DRAG = 4'd4;
  localparam logic [PH_W-1:0] PH_FDIV = 4'd5;
  localparam logic [PH_W-1:0] PH_AT   = 4'd6;
  localparam logic [PH_W-1:0] PH_ADIV = 4'd7;
  localparam logic [PH_W-1:0] PH_VT   = 4'd8;
  localparam logic [PH_W-1:0] PH_VDIV = 4'd9;

  localparam int SEQ_W = 5;
  localparam logic [SEQ_W-1:0] STEP_SQRT = 5'd3;
  localparam logic [SEQ_W-1:0] STEP_K    = 5'd4;
  localparam logic [SEQ_W-1:0] STEP_KM   = 5'd5;
  localparam logic [SEQ_W-1:0] STEP_DRAG = 5'd6;
  localparam logic [SEQ_W-1:0] STEP_FDIV = 5'd9;
  localparam logic [SEQ_W-1:0] STEP_TICK = 5'd12;
  localparam logic [SEQ_W-1:0] STEP_LAST = 5'd23;

  typedef struct packed {
    logic            load;
    logic            start;
    logic            finish;
    logic [PH_W-1:0] phase;
    logic [1:0]      idx;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic logic [PH_W-1:0] step_phase(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] j;
    j = seq - STEP_TICK;
    if (seq < STEP_SQRT) return PH_SQ;
    else if (seq == STEP_SQRT) return PH_SQRT;
    else if (seq == STEP_K) return PH_K;
    else if (seq == STEP_KM) return PH_KM;
    else if (seq < STEP_FDIV) return PH_DRAG;
    else if (seq < STEP_TICK) return PH_FDIV;
    else begin
      unique case (j[1:0])
        2'd0: return PH_AT;
        2'd1: return PH_ADIV;
        2'd2: return PH_VT;
        default: return PH_VDIV;
      endcase
    end
  endfunction

  function automatic logic [1:0] step_idx(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] j;
    j = seq - STEP_TICK;
    if (seq < STEP_SQRT) return seq[1:0];
    else if (seq >= STEP_DRAG && seq < STEP_FDIV) return 2'(seq - STEP_DRAG);
    else if (seq >= STEP_FDIV && seq < STEP_TICK) return 2'(seq - STEP_FDIV);
    else if (seq >= STEP_TICK) return j[3:2];
    else return 2'd0;
  endfunction

  function automatic logic [CAP_W-1:0] cap_q(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p >> FRAC_BITS;
    if (s[PROD_W-1:CAP_W] != '0 || s[CAP_W-1:0] > CAP_Q) return CAP_Q;
    else return s[CAP_W-1:0];
  endfunction

  function automatic logic [VEL_W-1:0] sat_vel(input logic [EXT_W-1:0] v);
    if (v[EXT_W-1:VEL_W-1] == '0 || v[EXT_W-1:VEL_W-1] == '1) return v[VEL_W-1:0];
    else return v[EXT_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
    if (v[POS_W] == v[POS_W-1]) return v[POS_W-1:0];
    else return v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

endpackage

// ===== rtl/rfps_mul.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics multiplier
// 64x64 unsigned product built from four registered 32x32 partial products.
// ----------------------------------------------------------------------------
module rfps_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rfps_pkg::OPND_W-1:0] a,
  input  logic [rfps_pkg::OPND_W-1:0] b,
  output logic                        done,
  output logic [rfps_pkg::PROD_W-1:0] prod
);
  import rfps_pkg::*;

  localparam int HALF_W = OPND_W / 2;
  localparam logic [2:0] PASSES = 3'd4;

  logic [OPND_W-1:0] opa;
  logic [OPND_W-1:0] opb;
  logic [OPND_W-1:0] pp;
  logic [1:0]        pp_sh;
  logic [2:0]        cnt;
  logic              busy;
  logic [HALF_W-1:0] ha;
  logic [HALF_W-1:0] hb;

  assign ha = cnt[0] ? opa[OPND_W-1:HALF_W] : opa[HALF_W-1:0];
  assign hb = cnt[1] ? opb[OPND_W-1:HALF_W] : opb[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opa  <= a;
        opb  <= b;
        prod <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != PASSES) begin
          pp    <= {{HALF_W{1'b0}}, ha} * {{HALF_W{1'b0}}, hb};
          pp_sh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt != '0) begin
          prod <= prod + (PROD_W'(pp) << {pp_sh, 5'b0});
        end
        if (cnt == PASSES) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/rfps_div.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics divider
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
// ----------------------------------------------------------------------------
module rfps_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rfps_pkg::DVD_W-1:0] dividend,
  input  logic [rfps_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [rfps_pkg::QBITS-1:0] quo,
  output logic                       ovf
);
  import rfps_pkg::*;

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [QBITS-1:0] lo;
  logic [5:0]       cnt;
  logic             busy;
  logic [DVS_W:0]   rem2;

  assign rem2 = {rem, lo[QBITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ovf  <= dividend[DVD_W-1:QBITS] >= (DVD_W-QBITS)'(divisor);
        rem  <= dividend[QBITS+DVS_W-1:QBITS];
        lo   <= dividend[QBITS-1:0];
        dvs  <= divisor;
        quo  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem2 >= {1'b0, dvs}) begin
          rem <= DVS_W'(rem2 - {1'b0, dvs});
          quo <= {quo[QBITS-2:0], 1'b1};
        end else begin
          rem <= rem2[DVS_W-1:0];
          quo <= {quo[QBITS-2:0], 1'b0};
        end
        lo  <= {lo[QBITS-2:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QBITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rfps_sqrt.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics square root
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rfps_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rfps_pkg::OPND_W-1:0] radicand,
  output logic                        done,
  output logic [rfps_pkg::DVS_W-1:0]  root
);
  import rfps_pkg::*;

  logic [OPND_W-1:0] v;
  logic [OPND_W-1:0] res;
  logic [OPND_W-1:0] bitv;
  logic [OPND_W-1:0] trial;
  logic [4:0]        cnt;
  logic              busy;

  assign trial = res + bitv;
  assign root  = res[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= radicand;
        res  <= '0;
        bitv <= OPND_W'(1) << (OPND_W - 2);
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rfps_dp.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics datapath
// State, configuration, arithmetic units and write-back of each step.
// ----------------------------------------------------------------------------
module rfps_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rfps_pkg::cmd_t              cmd,
  output rfps_pkg::stat_t             stat,
  input  logic                        cfg_wen,
  input  logic [rfps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rfps_pkg::CFG_W-1:0]  cfg_data,
  input  logic [rfps_pkg::MASS_W-1:0] mass,
  input  logic [rfps_pkg::AREA_W-1:0] drag_area,
  input  logic [rfps_pkg::THR_W-1:0]  thrust,
  output logic [rfps_pkg::POS_W-1:0]  pos_x,
  output logic [rfps_pkg::POS_W-1:0]  pos_y,
  output logic [rfps_pkg::POS_W-1:0]  pos_z,
  output logic [rfps_pkg::VEL_W-1:0]  vel_x,
  output logic [rfps_pkg::VEL_W-1:0]  vel_y,
  output logic [rfps_pkg::VEL_W-1:0]  vel_z,
  output logic [rfps_pkg::VEL_W-1:0]  acc_x,
  output logic [rfps_pkg::VEL_W-1:0]  acc_y,
  output logic [rfps_pkg::VEL_W-1:0]  acc_z,
  output logic                        has_landed,
  output logic [rfps_pkg::TIME_W-1:0] elapsed_us
);
  import rfps_pkg::*;

  logic [POS_W-1:0]  ground;
  logic [VEL_W-1:0]  wind [3];
  logic [VEL_W-1:0]  dragf;
  logic [TICK_W-1:0] tick;

  logic [POS_W-1:0]  pos [3];
  logic [VEL_W-1:0]  vel [3];
  logic [TIME_W-1:0] elapsed;
  logic              landed;

  logic [MASS_W-1:0] mass_r;
  logic [AREA_W-1:0] area_r;
  logic [THR_W-1:0]  thrust_r;
  logic [MAG_W-1:0]  amag [3];
  logic              rneg [3];
  logic              big;
  logic [OPND_W-1:0] sum;
  logic [MAG_W-1:0]  relmag;
  logic [CAP_W-1:0]  k;
  logic [CAP_W-1:0]  km;
  logic              fneg [3];
  logic [OPND_W-1:0] fmag [3];
  logic [VEL_W-1:0]  acc [3];
  logic [TMP_W-1:0]  tmp;
  logic              tneg;
  logic [VEL_W-1:0]  nv [3];
  logic [POS_W-1:0]  np [3];
  logic [VEL_W-1:0]  acc_out [3];

  logic [MAG_W-1:0]  rel_c [3];
  logic [MAG_W-1:0]  amag_c [3];
  logic              big_c;

  logic [OPND_W-1:0] mul_a;
  logic [OPND_W-1:0] mul_b;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic              mul_start;
  logic              div_start;
  logic              sqrt_start;
  logic              mul_done;
  logic              div_done;
  logic              sqrt_done;
  logic [PROD_W-1:0] prod;
  logic [QBITS-1:0]  quo;
  logic              ovf;
  logic [DVS_W-1:0]  root;
  logic [QBITS-1:0]  q_us;

  logic [MAG_W-1:0]  sel_amag;
  logic [MAG_W-1:0]  s_val;
  logic [VEL_W-1:0]  accmag;
  logic [VEL_W-1:0]  nvmag;
  logic [CAP_W-1:0]  d_c;
  logic [OPND_W:0]   f_c;
  logic [OPND_W:0]   fmag_c;
  logic [QBITS:0]    res_c;
  logic [EXT_W-1:0]  sv_c;
  logic [QBITS:0]    dv_c;
  logic [QBITS:0]    vsum_c;
  logic [POS_W:0]    dp_c;
  logic [POS_W:0]    psum_c;

  always_comb begin
    big_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rel_c[i]  = {wind[i][VEL_W-1], wind[i]} - {vel[i][VEL_W-1], vel[i]};
      amag_c[i] = rel_c[i][MAG_W-1] ? MAG_W'(0) - rel_c[i] : rel_c[i];
      big_c     = big_c | amag_c[i][MAG_W-1] | amag_c[i][MAG_W-2];
    end
  end

  assign sel_amag = amag[cmd.idx];
  assign s_val    = big ? (sel_amag >> 1) : sel_amag;
  assign accmag   = acc[cmd.idx][VEL_W-1] ? VEL_W'(0) - acc[cmd.idx] : acc[cmd.idx];
  assign nvmag    = nv[cmd.idx][VEL_W-1] ? VEL_W'(0) - nv[cmd.idx] : nv[cmd.idx];

  always_comb begin
    unique case (cmd.phase)
      PH_SQ: begin
        mul_a = OPND_W'(s_val);
        mul_b = OPND_W'(s_val);
      end
      PH_K: begin
        mul_a = OPND_W'(dragf);
        mul_b = OPND_W'(area_r);
      end
      PH_KM: begin
        mul_a = OPND_W'(k);
        mul_b = OPND_W'(relmag);
      end
      PH_DRAG: begin
        mul_a = OPND_W'(km);
        mul_b = OPND_W'(sel_amag);
      end
      PH_AT: begin
        mul_a = OPND_W'(accmag);
        mul_b = OPND_W'(tick);
      end
      PH_ADIV: begin
        mul_a = OPND_W'(tmp);
        mul_b = US_RECIP;
      end
      PH_VT: begin
        mul_a = OPND_W'(nvmag);
        mul_b = OPND_W'(tick);
      end
      PH_VDIV: begin
        mul_a = OPND_W'(tmp);
        mul_b = US_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dvd  = DVD_W'(fmag[cmd.idx]) << FRAC_BITS;
  assign dvs  = mass_r;
  assign q_us = prod[US_SHIFT +: QBITS];

  assign mul_start  = cmd.start && (cmd.phase == PH_SQ || cmd.phase == PH_K ||
                      cmd.phase == PH_KM || cmd.phase == PH_DRAG ||
                      cmd.phase == PH_AT || cmd.phase == PH_ADIV ||
                      cmd.phase == PH_VT || cmd.phase == PH_VDIV);
  assign div_start  = cmd.start && (cmd.phase == PH_FDIV);
  assign sqrt_start = cmd.start && (cmd.phase == PH_SQRT);
  assign stat.done  = mul_done | div_done | sqrt_done;

  rfps_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  rfps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quo      (quo),
    .ovf      (ovf)
  );

  rfps_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    d_c    = cap_q(prod);
    f_c    = rneg[cmd.idx] ? (OPND_W+1)'(0) - (OPND_W+1)'(d_c) : (OPND_W+1)'(d_c);
    if (cmd.idx == 2'd2) begin
      f_c = f_c + (OPND_W+1)'(thrust_r);
    end
    fmag_c = f_c[OPND_W] ? (OPND_W+1)'(0) - f_c : f_c;
    res_c  = ovf ? ((QBITS+1)'(1) << QBITS) : {1'b0, quo};
    sv_c   = fneg[cmd.idx] ? EXT_W'(0) - EXT_W'(res_c) : EXT_W'(res_c);
    if (cmd.idx == 2'd2) begin
      sv_c = sv_c - GRAV_Q;
    end
    dv_c   = tneg ? (QBITS+1)'(0) - {1'b0, q_us} : {1'b0, q_us};
    vsum_c = {{(QBITS+1-VEL_W){vel[cmd.idx][VEL_W-1]}}, vel[cmd.idx]} + dv_c;
    dp_c   = tneg ? (POS_W+1)'(0) - (POS_W+1)'(q_us) : (POS_W+1)'(q_us);
    psum_c = {pos[cmd.idx][POS_W-1], pos[cmd.idx]} + dp_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ground  <= '0;
      dragf   <= '0;
      tick    <= TICK_RESET;
      elapsed <= '0;
      landed  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wind[i] <= '0;
        pos[i]  <= '0;
        vel[i]  <= '0;
      end
    end else begin
      if (cmd.load) begin
        mass_r   <= (mass == '0) ? MASS_W'(1) : mass;
        area_r   <= drag_area;
        thrust_r <= thrust;
        big      <= big_c;
        sum      <= '0;
        for (int i = 0; i < 3; i++) begin
          amag[i] <= amag_c[i];
          rneg[i] <= rel_c[i][MAG_W-1];
        end
      end
      if (stat.done) begin
        unique case (cmd.phase)
          PH_SQ:   sum <= sum + prod[OPND_W-1:0];
          PH_SQRT: relmag <= big ? {root, 1'b0} : {1'b0, root};
          PH_K:    k <= d_c;
          PH_KM:   km <= d_c;
          PH_DRAG: begin
            fneg[cmd.idx] <= f_c[OPND_W];
            fmag[cmd.idx] <= fmag_c[OPND_W-1:0];
          end
          PH_FDIV: acc[cmd.idx] <= sat_vel(sv_c);
          PH_AT: begin
            tmp  <= prod[TMP_W-1:0];
            tneg <= acc[cmd.idx][VEL_W-1];
          end
          PH_ADIV: nv[cmd.idx] <= sat_vel(EXT_W'($signed(vsum_c)));
          PH_VT: begin
            tmp  <= prod[TMP_W-1:0];
            tneg <= nv[cmd.idx][VEL_W-1];
          end
          PH_VDIV: np[cmd.idx] <= sat_pos(psum_c);
          default: ;
        endcase
      end
      if (cmd.finish) begin
        elapsed <= elapsed + TIME_W'(tick);
        for (int i = 0; i < 3; i++) begin
          acc_out[i] <= acc[i];
        end
        if ($signed(np[2]) < $signed(ground)) begin
          pos[0] <= np[0];
          pos[1] <= np[1];
          pos[2] <= ground;
          if ($signed(nv[2]) < $signed(NEG_SINK_Q)) begin
            landed <= 1'b1;
          end
          for (int i = 0; i < 3; i++) begin
            vel[i] <= '0;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            pos[i] <= np[i];
            vel[i] <= nv[i];
          end
        end
      end
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_GROUND: begin
            ground <= cfg_data;
            pos[2] <= cfg_data;
          end
          REG_WIND_X: wind[0] <= cfg_data[VEL_W-1:0];
          REG_WIND_Y: wind[1] <= cfg_data[VEL_W-1:0];
          REG_WIND_Z: wind[2] <= cfg_data[VEL_W-1:0];
          REG_DRAG:   dragf <= cfg_data[VEL_W-1:0];
          REG_TICK:   tick <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign pos_x      = pos[0];
  assign pos_y      = pos[1];
  assign pos_z      = pos[2];
  assign vel_x      = vel[0];
  assign vel_y      = vel[1];
  assign vel_z      = vel[2];
  assign acc_x      = acc_out[0];
  assign acc_y      = acc_out[1];
  assign acc_z      = acc_out[2];
  assign has_landed = landed;
  assign elapsed_us = elapsed;

endmodule

// ===== rtl/rfps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics controller
// Sequences the arithmetic steps of one tick and owns both handshakes.
// ----------------------------------------------------------------------------
module rfps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rfps_pkg::cmd_t  cmd,
  input  rfps_pkg::stat_t stat
);
  import rfps_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [SEQ_W-1:0] seq;
  logic [SEQ_W-1:0] seq_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.start  = (state == S_START);
  assign cmd.finish = (state == S_FIN) && (!out_valid || out_ready);
  assign cmd.phase  = step_phase(seq);
  assign cmd.idx    = step_idx(seq);

  always_comb begin
    state_next = state;
    seq_next   = seq;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_START;
          seq_next   = '0;
        end
      end
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          if (seq == STEP_LAST) begin
            state_next = S_FIN;
          end else begin
            state_next = S_START;
            seq_next   = seq + SEQ_W'(1);
          end
        end
      end
      default: begin
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seq       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rocket_flight_physics_step_unit.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics step unit
// One semi-implicit Euler tick of a point-mass rocket per input beat.
//
//   channel   signals                               beat
//   in        in_valid / in_ready                   mass, drag_area, thrust
//   out       out_valid / out_ready                 position, velocity, accel,
//                                                   landed flag, elapsed time
//   cfg       cfg_wen, cfg_index, cfg_data          one register write
//
// A tick is made of twenty multiplies (six of them by the reciprocal of one
// million), three divisions by mass and one square root, then a finish step.
// One tick is worked at a time; the next input beat is taken as soon as the
// result is in the output register, while that result waits for out_ready.
// A result that is not taken holds the block before its state update.
// Reset is synchronous.
// ----------------------------------------------------------------------------
`include "rocket_flight_physics_step_unit_macros.svh"

module rocket_flight_physics_step_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rfps_pkg::MASS_W-1:0] mass,
  input  logic [rfps_pkg::AREA_W-1:0] drag_area,
  input  logic [rfps_pkg::THR_W-1:0]  thrust,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfps_pkg::POS_W-1:0]  pos_x,
  output logic [rfps_pkg::POS_W-1:0]  pos_y,
  output logic [rfps_pkg::POS_W-1:0]  pos_z,
  output logic [rfps_pkg::VEL_W-1:0]  vel_x,
  output logic [rfps_pkg::VEL_W-1:0]  vel_y,
  output logic [rfps_pkg::VEL_W-1:0]  vel_z,
  output logic [rfps_pkg::VEL_W-1:0]  acc_x,
  output logic [rfps_pkg::VEL_W-1:0]  acc_y,
  output logic [rfps_pkg::VEL_W-1:0]  acc_z,
  output logic                        has_landed,
  output logic [rfps_pkg::TIME_W-1:0] elapsed_us,
  input  logic                        cfg_wen,
  input  logic [rfps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rfps_pkg::CFG_W-1:0]  cfg_data
);
  import rfps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rfps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mass       (mass),
    .drag_area  (drag_area),
    .thrust     (thrust),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .vel_z      (vel_z),
    .acc_x      (acc_x),
    .acc_y      (acc_y),
    .acc_z      (acc_z),
    .has_landed (has_landed),
    .elapsed_us (elapsed_us)
  );

  `RFPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input taken while a tick is in progress")
  `RFPS_ASSERT_NEXT(a_landed_sticky, clk, rst, has_landed, has_landed, "landed flag cleared")
  `RFPS_ASSERT_SAME(a_result_ends_tick, clk, rst, $rose(out_valid), in_ready, "result raised while a tick is still running")

endmodule

// ===== bench/tb_rocket_flight_physics_step_unit.sv =====
// ----------------------------------------------------------------------------
// Rocket flight physics step unit testbench
// Drives ticks of mass, drag area and thrust through the valid/ready input
// and checks every result beat field by field against a fixed-point flight
// predictor. The register settings change between phases while the unit is
// idle. A directed table comes first, then random phases, with random stalls
// on both sides except in phases 8 to 11.
// ----------------------------------------------------------------------------
module tb_rocket_flight_physics_step_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rfps_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TARGET_TICKS = 1350;
  localparam longint GRAVITY_Q = ((64'd981 << 16) + 64'd50) / 64'd100;
  localparam longint SINK_LIMIT_Q = ((64'd1 << 16) + 64'd5) / 64'd10;
  localparam longint US_PER_S = 1000000;

  typedef struct {
    logic [POS_W-1:0]  px, py, pz;
    logic [VEL_W-1:0]  vx, vy, vz, ax, ay, az;
    logic              landed;
    logic [TIME_W-1:0] t_us;
  } tick_result_t;

  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  data;
    logic [MASS_W-1:0] m;
    logic [AREA_W-1:0] a;
    logic [THR_W-1:0]  t;
    bit                has_exp;
    logic [POS_W-1:0]  exp_pz;
    logic [VEL_W-1:0]  exp_vz;
    logic [VEL_W-1:0]  exp_az;
    logic [TIME_W-1:0] exp_t;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MASS_W-1:0] mass = '0;
  logic [AREA_W-1:0] drag_area = '0;
  logic [THR_W-1:0] thrust = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [VEL_W-1:0] vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
  logic has_landed;
  logic [TIME_W-1:0] elapsed_us;
  logic cfg_wen = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  rocket_flight_physics_step_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mass(mass), .drag_area(drag_area), .thrust(thrust),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .has_landed(has_landed), .elapsed_us(elapsed_us),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Flight state and register copies.
  longint pos_s[3];
  longint vel_s[3];
  longint wind_s[3];
  longint ground_s;
  bit [63:0] drag_s;
  longint tick_s;
  bit [TIME_W-1:0] elapsed_s;
  bit landed_s;

  tick_result_t pending_ticks[$];
  row_t rows[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int ticks_checked = 0;
  int landed_seen = 0;
  int phases = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] res = 0;
    bit [63:0] b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] mul_frac(bit [63:0] x, bit [63:0] y);
    bit [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) >> 16;
    if (p > (128'd1 << 62)) return 64'd1 << 62;
    return p[63:0];
  endfunction

  function automatic longint div_by_mass(longint f, bit [63:0] m);
    bit [63:0] mg, q, r, res;
    mg = (f < 0) ? 64'(-f) : 64'(f);
    if (m == 0) m = 1;
    q = mg / m;
    r = mg % m;
    if (q >= (64'd1 << 36)) res = 64'd1 << 60;
    else res = (q << 16) + ((r << 16) / m);
    return (f < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint clamp_w(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  task automatic reset_flight();
    ground_s = 0;
    wind_s = '{0, 0, 0};
    drag_s = 0;
    tick_s = 1000;
    pos_s = '{0, 0, 0};
    vel_s = '{0, 0, 0};
    elapsed_s = 0;
    landed_s = 0;
  endtask

  task automatic apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_GROUND: begin
        ground_s = $signed(d[39:0]);
        pos_s[2] = ground_s;
      end
      REG_WIND_X: wind_s[0] = $signed(d[31:0]);
      REG_WIND_Y: wind_s[1] = $signed(d[31:0]);
      REG_WIND_Z: wind_s[2] = $signed(d[31:0]);
      REG_DRAG: drag_s = {32'd0, d[31:0]};
      REG_TICK: tick_s = longint'(d[19:0]);
      default: ;
    endcase
  endtask

  task automatic advance_flight(logic [MASS_W-1:0] m, logic [AREA_W-1:0] ar,
                                logic [THR_W-1:0] th, output tick_result_t r);
    longint rel[3], force_v[3], acc[3], nv[3], np[3];
    bit [63:0] mg[3], s, sum, rmag, k, km;
    bit big;
    sum = 0;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = wind_s[i] - vel_s[i];
      mg[i] = (rel[i] < 0) ? 64'(-rel[i]) : 64'(rel[i]);
      if (mg[i] >= (64'd1 << 31)) big = 1;
    end
    for (int i = 0; i < 3; i++) begin
      s = big ? (mg[i] >> 1) : mg[i];
      sum += s * s;
    end
    rmag = root64(sum) << big;
    k = mul_frac(drag_s, {32'd0, ar});
    km = mul_frac(k, rmag);
    for (int i = 0; i < 3; i++) begin
      force_v[i] = longint'(mul_frac(km, mg[i]));
      if (rel[i] < 0) force_v[i] = -force_v[i];
    end
    force_v[2] += longint'({28'd0, th});
    for (int i = 0; i < 3; i++) acc[i] = div_by_mass(force_v[i], {32'd0, m});
    acc[2] -= GRAVITY_Q;
    for (int i = 0; i < 3; i++) begin
      acc[i] = clamp_w(acc[i], 32);
      nv[i] = clamp_w(vel_s[i] + (acc[i] * tick_s) / US_PER_S, 32);
      np[i] = clamp_w(pos_s[i] + (nv[i] * tick_s) / US_PER_S, 40);
    end
    if (np[2] < ground_s) begin
      np[2] = ground_s;
      if (nv[2] < -SINK_LIMIT_Q) landed_s = 1;
      nv = '{0, 0, 0};
    end
    elapsed_s = elapsed_s + 48'(tick_s);
    pos_s = np;
    vel_s = nv;
    r.px = 40'(np[0]); r.py = 40'(np[1]); r.pz = 40'(np[2]);
    r.vx = 32'(nv[0]); r.vy = 32'(nv[1]); r.vz = 32'(nv[2]);
    r.ax = 32'(acc[0]); r.ay = 32'(acc[1]); r.az = 32'(acc[2]);
    r.landed = landed_s;
    r.t_us = elapsed_s;
  endtask

  task automatic report_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      $display("MISMATCH tick %0d %s: got %h, expected %h", ticks_checked, name, got,
               want);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    apply_register(idx, d);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(logic [MASS_W-1:0] m, logic [AREA_W-1:0] ar,
                           logic [THR_W-1:0] th);
    tick_result_t r;
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 15);
    end
    in_valid <= 1'b1;
    mass <= m;
    drag_area <= ar;
    thrust <= th;
    do @(posedge clk); while (!in_ready);
    advance_flight(m, ar, th, r);
    pending_ticks = {pending_ticks, r};
    ticks_sent++;
  endtask

  always @(posedge clk) begin
    tick_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        mismatches++;
        $display("MISMATCH: result beat with no tick outstanding");
      end else begin
        w = pending_ticks.pop_front();
        report_field("pos_x", pos_x, w.px);
        report_field("pos_y", pos_y, w.py);
        report_field("pos_z", pos_z, w.pz);
        report_field("vel_x", vel_x, w.vx);
        report_field("vel_y", vel_y, w.vy);
        report_field("vel_z", vel_z, w.vz);
        report_field("acc_x", acc_x, w.ax);
        report_field("acc_y", acc_y, w.ay);
        report_field("acc_z", acc_z, w.az);
        report_field("has_landed", has_landed, w.landed);
        report_field("elapsed_us", elapsed_us, w.t_us);
        if (w.landed) landed_seen++;
        ticks_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic row_t tick_row(logic [MASS_W-1:0] m, logic [AREA_W-1:0] ar,
                                    logic [THR_W-1:0] th);
    row_t r;
    r = '{default: '0};
    r.m = m; r.a = ar; r.t = th;
    return r;
  endfunction

  function automatic row_t reg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.idx = idx; r.data = d;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows = {rows, r};
  endfunction

  initial begin
    row_t r0;
    int n_items;
    bit wide;
    longint g;
    logic [THR_W-1:0] th;

    reset_flight();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At rest after reset only gravity acts: one 1 ms tick at 1 kg.
    r0 = tick_row(32'h0001_0000, 32'd0, 36'd0);
    r0.has_exp = 1;
    r0.exp_pz = 40'd0;
    r0.exp_vz = -32'sd642;
    r0.exp_az = -32'sd642908;
    r0.exp_t = 48'd1000;
    add_row(r0);
    add_row(tick_row(32'd0, 32'hFFFF_FFFF, 36'hF_FFFF_FFFF));
    add_row(tick_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 36'd0));
    add_row(tick_row(32'd1, 32'd1, 36'd1));
    add_row(reg_row(REG_DRAG, 40'hFF_FFFF_FFFF));
    add_row(reg_row(REG_WIND_X, 40'h7FFF_FFFF));
    add_row(reg_row(REG_WIND_Y, 40'h8000_0000));
    add_row(reg_row(REG_WIND_Z, 40'h0));
    add_row(tick_row(32'h0001_0000, 32'h0001_0000, 36'd0));
    add_row(tick_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 36'hF_FFFF_FFFF));
    add_row(reg_row(REG_TICK, 40'd0));
    add_row(tick_row(32'h0001_0000, 32'h0000_8000, 36'h1_0000));
    add_row(reg_row(REG_TICK, 40'd1000000));
    add_row(tick_row(32'h0010_0000, 32'h0001_0000, 36'h0));
    add_row(reg_row(REG_TICK, 40'hF_FFFF));
    add_row(tick_row(32'h0001_0000, 32'd0, 36'h0));
    add_row(reg_row(REG_WIND_X, 40'h0));
    add_row(reg_row(REG_WIND_Y, 40'h0));
    add_row(reg_row(REG_DRAG, 40'h0));
    add_row(reg_row(REG_GROUND, 40'h0));
    add_row(tick_row(32'd0, 32'd0, 36'd0));
    add_row(tick_row(32'h0001_0000, 32'd0, 36'd0));
    add_row(reg_row(REG_GROUND, 40'h7F_FFFF_FFFF));
    add_row(tick_row(32'd1, 32'd0, 36'hF_FFFF_FFFF));
    add_row(reg_row(REG_GROUND, 40'h80_0000_0000));
    add_row(tick_row(32'h0001_0000, 32'd0, 36'd0));
    add_row(reg_row(3'd6, 40'hAA_5555_AAAA));
    add_row(reg_row(3'd7, 40'h55_AAAA_5555));
    add_row(tick_row(32'h0001_0000, 32'd0, 36'd0));
    add_row(reg_row(REG_TICK, 40'd1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_register(rows[i].idx, rows[i].data);
      end else begin
        send_tick(rows[i].m, rows[i].a, rows[i].t);
        if (rows[i].has_exp) begin
          pending_ticks[$].pz = rows[i].exp_pz;
          pending_ticks[$].vz = rows[i].exp_vz;
          pending_ticks[$].az = rows[i].exp_az;
          pending_ticks[$].t_us = rows[i].exp_t;
        end
      end
    end

    while (ticks_sent < TARGET_TICKS) begin
      drain();
      phases++;
      steady = (phases >= 8 && phases <= 11);
      if ($urandom_range(3) == 0) begin
        write_register(REG_GROUND, 40'({$urandom, $urandom}));
        write_register(REG_WIND_X, {8'd0, $urandom});
        write_register(REG_WIND_Y, {8'd0, $urandom});
        write_register(REG_WIND_Z, {8'd0, $urandom});
        write_register(REG_DRAG, {8'd0, $urandom});
        write_register(REG_TICK, 40'($urandom_range(0, 20'hF_FFFF)));
      end else begin
        g = longint'($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
        write_register(REG_GROUND, 40'(g));
        g = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
        write_register(REG_WIND_X, 40'(g));
        g = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
        write_register(REG_WIND_Y, 40'(g));
        g = longint'($urandom_range(0, 10 * 65536)) - 5 * 65536;
        write_register(REG_WIND_Z, 40'(g));
        write_register(REG_DRAG, 40'($urandom_range(0, 65536)));
        write_register(REG_TICK, 40'($urandom_range(1, 20000)));
      end
      n_items = $urandom_range(30, 80);
      for (int j = 0; j < n_items; j++) begin
        wide = ($urandom_range(99) < 20);
        if (wide) begin
          th = 36'({$urandom, $urandom});
          send_tick($urandom, $urandom, th);
        end else begin
          th = ($urandom_range(1) == 0) ? 36'd0 : 36'($urandom_range(0, 3000 * 65536));
          send_tick($urandom_range(65536, 200 * 65536), $urandom_range(0, 65536), th);
        end
      end
    end
    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d ticks over %0d random register phases; %0d results checked.",
             ticks_sent, phases, ticks_checked);
    $display("Results with the landed flag set: %0d; mismatches: %0d.", landed_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rfps_pkg.sv
rtl/rfps_mul.sv
rtl/rfps_div.sv
rtl/rfps_sqrt.sv
rtl/rfps_dp.sv
rtl/rfps_ctrl.sv
rtl/rocket_flight_physics_step_unit.sv
bench/tb_rocket_flight_physics_step_unit.sv
